[rtl/pid_controller_antiwindup_assert.svh]
// assertion macros for the pid controller rtl
// expects a clock named aclk and an active-low synchronous reset named aresetn
`ifndef PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH
`define PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PIDAW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PIDAW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pidaw_pkg.sv]
// shared constants, codes and saturation helpers for the pid controller
// no dependencies
package pidaw_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int LIMIT_W    = 31;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int PROD_W     = 2 * DATA_W;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // operation codes of an input beat
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // controller modes; the unused code runs as full pid
    typedef enum logic [MODE_W-1:0] {
        MODE_PID = 2'd0,
        MODE_PI  = 2'd1,
        MODE_PD  = 2'd2
    } mode_t;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MODE     = 3'd0,
        REG_KP       = 3'd1,
        REG_KI_TS    = 3'd2,
        REG_KD_TS    = 3'd3,
        REG_LIMIT    = 3'd4,
        REG_DEADBAND = 3'd5
    } cfg_reg_t;

    // product back to fixed point: floor shift, then saturate
    function automatic logic signed [DATA_W-1:0] sat_prod(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W-1:0]   sh;
        logic [PROD_W-DATA_W:0]     upper;
        sh    = prod >>> FRAC_BITS;
        upper = sh[PROD_W-1:DATA_W-1];
        if ((upper == '0) || (upper == '1)) begin
            return sh[DATA_W-1:0];
        end
        return sh[PROD_W-1] ? DATA_MIN : DATA_MAX;
    endfunction

    // one-bit-grown sum back to data width with saturation
    function automatic logic signed [DATA_W-1:0] sat_sum(
        input logic signed [DATA_W:0] v
    );
        if (v[DATA_W] != v[DATA_W-1]) begin
            return v[DATA_W] ? DATA_MIN : DATA_MAX;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

[rtl/pid_controller_antiwindup.sv]
// pid controller with deadband and clamping anti-windup, signed fixed point
// depends on pidaw_pkg and pid_controller_antiwindup_assert.svh
//
//   channel | direction | ports                                   | payload
//   s_      | in        | s_valid s_ready                         | s_operation s_error_sample
//   m_      | out       | m_valid m_ready                         | m_drive
//   cfg_    | in        | cfg_valid cfg_ready                     | cfg_addr cfg_wdata
//
// one beat per cycle sustained while the output is not stalled; a result passes through each stage below in order
// stages: input register, multiplier register (three 32x32 products), result register
// the integral update sits in the last stage, the last-error update in the first
// reset clears configuration, integral and last error at once; no clearing pass
// an output stall holds the pipeline; empty stages still fill behind it
`include "pid_controller_antiwindup_assert.svh"

module pid_controller_antiwindup (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic signed [pidaw_pkg::DATA_W-1:0] s_error_sample,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pidaw_pkg::DATA_W-1:0] m_drive,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pidaw_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pidaw_pkg::DATA_W-1:0]        cfg_wdata
);
    import pidaw_pkg::*;

    // configuration registers
    logic [MODE_W-1:0]         mode_reg;
    logic signed [DATA_W-1:0]  kp_reg;
    logic signed [DATA_W-1:0]  ki_ts_reg;
    logic signed [DATA_W-1:0]  kd_ts_reg;
    logic [LIMIT_W-1:0]        limit_reg;
    logic [LIMIT_W-1:0]        deadband_reg;

    // controller state
    logic signed [DATA_W-1:0]  integral_reg, integral_next;
    logic signed [DATA_W-1:0]  prev_err_reg, prev_err_next;

    // stage 0: input register
    logic                      v0_reg;
    logic                      clr0_reg;
    logic signed [DATA_W-1:0]  err0_reg;

    // stage 1: product register
    logic                      v1_reg;
    logic                      clr1_reg;
    logic                      zero1_reg;
    logic                      epos1_reg, eneg1_reg;
    logic signed [PROD_W-1:0]  prod_p_reg, prod_i_reg, prod_d_reg;

    // result register
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  drive_reg, drive_next;

    // pipeline advance
    logic adv_out, adv1, adv0;

    // stage 0 combinational
    logic                      is_pd, is_pi;
    logic signed [DATA_W:0]    err33, db33;
    logic                      in_band;
    logic signed [DATA_W-1:0]  err_eff;
    logic signed [DATA_W-1:0]  diff_sat, diff_used;
    logic signed [PROD_W-1:0]  prod_p_next, prod_i_next, prod_d_next;

    // stage 1 combinational
    logic signed [DATA_W-1:0]  p_val, i_val, d_val, ni_val;
    logic signed [DATA_W+1:0]  pd34, sum34, lim34, drive34, aw34;
    logic                      clamped, commit;

    assign adv_out   = !out_valid_reg || m_ready;
    assign adv1      = !v1_reg || adv_out;
    assign adv0      = !v0_reg || adv1;
    assign s_ready   = adv0;
    assign m_valid   = out_valid_reg;
    assign m_drive   = drive_reg;
    assign cfg_ready = 1'b1;

    assign is_pd = (mode_reg == MODE_PD);
    assign is_pi = (mode_reg == MODE_PI);

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_PID;
            kp_reg       <= '0;
            ki_ts_reg    <= '0;
            kd_ts_reg    <= '0;
            limit_reg    <= '0;
            deadband_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_MODE:     mode_reg     <= cfg_wdata[MODE_W-1:0];
                REG_KP:       kp_reg       <= cfg_wdata;
                REG_KI_TS:    ki_ts_reg    <= cfg_wdata;
                REG_KD_TS:    kd_ts_reg    <= cfg_wdata;
                REG_LIMIT:    limit_reg    <= cfg_wdata[LIMIT_W-1:0];
                REG_DEADBAND: deadband_reg <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // deadband, error difference and products
    always_comb begin
        err33     = {err0_reg[DATA_W-1], err0_reg};
        db33      = {{(DATA_W+1-LIMIT_W){1'b0}}, deadband_reg};
        in_band   = (err33 <= db33) && (err33 >= -db33);
        err_eff   = in_band ? '0 : err0_reg;
        diff_sat  = sat_sum({err_eff[DATA_W-1], err_eff} - {prev_err_reg[DATA_W-1], prev_err_reg});
        diff_used = is_pi ? '0 : diff_sat;
        prod_p_next = PROD_W'(kp_reg) * PROD_W'(err_eff);
        prod_i_next = PROD_W'(ki_ts_reg) * PROD_W'(err_eff);
        prod_d_next = PROD_W'(kd_ts_reg) * PROD_W'(diff_used);
        // last error: a clear zeroes it, otherwise pi keeps it and every other mode stores the deadband-zeroed error
        prev_err_next = prev_err_reg;
        if (v0_reg && adv1) begin
            if (clr0_reg == OP_CLEAR) begin
                prev_err_next = '0;
            end else if (!is_pi) begin
                prev_err_next = err_eff;
            end
        end
    end

    // sum, clamp and anti-windup decision
    always_comb begin
        p_val   = sat_prod(prod_p_reg);
        i_val   = sat_prod(prod_i_reg);
        d_val   = sat_prod(prod_d_reg);
        ni_val  = sat_sum({integral_reg[DATA_W-1], integral_reg} + {i_val[DATA_W-1], i_val});
        pd34    = (DATA_W+2)'(p_val) + (DATA_W+2)'(d_val);
        sum34   = is_pd ? pd34 : pd34 + (DATA_W+2)'(ni_val);
        lim34   = {3'b000, limit_reg};
        clamped = 1'b1;
        if (sum34 > lim34) begin
            drive34 = lim34;
        end else if (sum34 < -lim34) begin
            drive34 = -lim34;
        end else begin
            drive34 = sum34;
            clamped = 1'b0;
        end
        // keep the new integral unless the drive is clamped and drive minus the p and d terms has the error's sign
        aw34   = drive34 - pd34;
        commit = !clamped ||
                 !((!aw34[DATA_W+1] && (aw34 != '0) && epos1_reg) ||
                   (aw34[DATA_W+1] && eneg1_reg));

        drive_next    = drive34[DATA_W-1:0];
        integral_next = integral_reg;
        if (clr1_reg == OP_CLEAR) begin
            drive_next    = '0;
            integral_next = '0;
        end else if (zero1_reg) begin
            drive_next = '0;
        end else if (!is_pd && commit) begin
            integral_next = ni_val;
        end
        if (!(v1_reg && adv_out)) begin
            integral_next = integral_reg;
        end
    end

    // pipeline control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
            prev_err_reg  <= '0;
        end else begin
            integral_reg <= integral_next;
            prev_err_reg <= prev_err_next;
            if (adv0) begin
                v0_reg <= s_valid;
            end
            if (adv1) begin
                v1_reg <= v0_reg;
            end
            if (adv_out) begin
                out_valid_reg <= v1_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (adv0 && s_valid) begin
            clr0_reg <= s_operation;
            err0_reg <= s_error_sample;
        end
        if (adv1 && v0_reg) begin
            clr1_reg   <= clr0_reg;
            zero1_reg  <= is_pd && in_band;
            epos1_reg  <= !err_eff[DATA_W-1] && (err_eff != '0);
            eneg1_reg  <= err_eff[DATA_W-1];
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
        if (adv_out && v1_reg) begin
            drive_reg <= drive_next;
        end
    end

    `PIDAW_ASSERT_NXT(a_clear_zeroes_integral, v1_reg && (clr1_reg == OP_CLEAR) && adv_out, (integral_reg == '0) && m_valid && (m_drive == '0), "clear beat did not zero integral and drive")
    `PIDAW_ASSERT_NXT(a_clear_zeroes_prev, v0_reg && (clr0_reg == OP_CLEAR) && adv1, prev_err_reg == '0, "clear beat did not zero last error")
    `PIDAW_ASSERT_NXT(a_pd_band_zero, v1_reg && zero1_reg && (clr1_reg == OP_STEP) && adv_out, m_valid && (m_drive == '0), "pd deadband beat gave nonzero drive")
    `PIDAW_ASSERT_NXT(a_stage1_holds, v1_reg && !adv_out, v1_reg, "product stage dropped a beat under stall")

endmodule

[bench/pid_controller_antiwindup_checker.sv]
// drive checker for the pid controller: watches all three channels, predicts each drive beat
// depends on pidaw_pkg for widths, mode codes and register indexes
module pid_controller_antiwindup_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_operation,
    input  logic signed [pidaw_pkg::DATA_W-1:0] s_error_sample,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [pidaw_pkg::DATA_W-1:0] m_drive,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [pidaw_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pidaw_pkg::DATA_W-1:0]        cfg_wdata,
    output int                                  bad_beats,
    output int                                  pending,
    output int                                  drives_seen
);
    import pidaw_pkg::*;

    // shadow copy of the registers
    logic [MODE_W-1:0]         ctl_mode;
    logic signed [DATA_W-1:0]  gain_p;
    logic signed [DATA_W-1:0]  gain_i;
    logic signed [DATA_W-1:0]  gain_d;
    logic [LIMIT_W-1:0]        clamp_mag;
    logic [LIMIT_W-1:0]        band_mag;

    // shadow controller state
    logic signed [DATA_W-1:0]  acc_int;
    logic signed [DATA_W-1:0]  last_err;

    // drives still owed by the block, oldest first
    logic signed [DATA_W-1:0]  drive_due[$];

    function automatic logic signed [DATA_W-1:0] sat32(input longint v);
        if (v > longint'(DATA_MAX)) begin
            return DATA_MAX;
        end
        if (v < longint'(DATA_MIN)) begin
            return DATA_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    // q-format product: floor shift of the exact product, then saturate
    function automatic logic signed [DATA_W-1:0] fx_mul(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        longint prod;
        prod = longint'(a) * longint'(b);
        return sat32(prod >>> FRAC_BITS);
    endfunction

    function automatic int sgn(input longint v);
        if (v > 0) begin
            return 1;
        end
        if (v < 0) begin
            return -1;
        end
        return 0;
    endfunction

    // one control law update; returns the drive and advances the shadow state
    function automatic logic signed [DATA_W-1:0] step_law(
        input logic                    op,
        input logic signed [DATA_W-1:0] err_in
    );
        logic signed [DATA_W-1:0] e;
        logic signed [DATA_W-1:0] p;
        logic signed [DATA_W-1:0] d;
        logic signed [DATA_W-1:0] ni;
        longint                   lim;
        longint                   band;
        longint                   pd;
        longint                   total;
        longint                   out;
        logic                     in_band;
        e    = err_in;
        lim  = 0;
        band = 0;
        lim[LIMIT_W-1:0]  = clamp_mag;
        band[LIMIT_W-1:0] = band_mag;
        if (op == OP_CLEAR) begin
            acc_int  = '0;
            last_err = '0;
            return '0;
        end
        in_band = (longint'(e) >= -band) && (longint'(e) <= band);
        // pd only: deadband exits early and forgets the last error
        if (ctl_mode == MODE_PD) begin
            if (in_band) begin
                last_err = '0;
                return '0;
            end
            d        = fx_mul(gain_d, sat32(longint'(e) - longint'(last_err)));
            p        = fx_mul(gain_p, e);
            last_err = e;
            total    = longint'(p) + longint'(d);
        end else begin
            if (in_band) begin
                e = '0;
            end
            p = fx_mul(gain_p, e);
            d = '0;
            if (ctl_mode != MODE_PI) begin
                d        = fx_mul(gain_d, sat32(longint'(e) - longint'(last_err)));
                last_err = e;
            end
            ni    = sat32(longint'(acc_int) + longint'(fx_mul(gain_i, e)));
            pd    = longint'(p) + longint'(d);
            total = pd + longint'(ni);
        end
        // symmetric clamp
        out = total;
        if (total > lim) begin
            out = lim;
        end else if (total < -lim) begin
            out = -lim;
        end
        // clamping anti-windup: keep the integral only when it would not push further out
        if (ctl_mode != MODE_PD) begin
            if (out != total) begin
                if (sgn(out - pd) * sgn(longint'(e)) <= 0) begin
                    acc_int = ni;
                end
            end else begin
                acc_int = ni;
            end
        end
        return out[DATA_W-1:0];
    endfunction

    // sample all channels at the clock edge; results before new beats
    always @(posedge aclk) begin : watch
        logic signed [DATA_W-1:0] due;
        if (!aresetn) begin
            ctl_mode    = MODE_PID;
            gain_p      = '0;
            gain_i      = '0;
            gain_d      = '0;
            clamp_mag   = '0;
            band_mag    = '0;
            acc_int     = '0;
            last_err    = '0;
            drive_due.delete();
            bad_beats   = 0;
            drives_seen = 0;
            pending    <= 0;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_MODE:     ctl_mode  = cfg_wdata[MODE_W-1:0];
                    REG_KP:       gain_p    = cfg_wdata;
                    REG_KI_TS:    gain_i    = cfg_wdata;
                    REG_KD_TS:    gain_d    = cfg_wdata;
                    REG_LIMIT:    clamp_mag = cfg_wdata[LIMIT_W-1:0];
                    REG_DEADBAND: band_mag  = cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            // compare a drive beat with the oldest prediction
            if (m_valid && m_ready) begin
                drives_seen = drives_seen + 1;
                if (drive_due.size() == 0) begin
                    $display("%0t: drive beat with nothing pending: expected none, actual %0d",
                             $time, m_drive);
                    bad_beats = bad_beats + 1;
                end else begin
                    due = drive_due.pop_front();
                    if (m_drive !== due) begin
                        $display("%0t: drive wrong: expected %0d, actual %0d",
                                 $time, due, m_drive);
                        bad_beats = bad_beats + 1;
                    end
                end
            end
            // predict for each accepted input beat
            if (s_valid && s_ready) begin
                drive_due.push_back(step_law(s_operation, s_error_sample));
            end
            pending <= drive_due.size();
        end
    end

endmodule

[bench/pid_controller_antiwindup_tb.sv]
// top of the pid controller bench: clock, reset, register programming, stimulus and verdict
// depends on pidaw_pkg, pid_controller_antiwindup and pid_controller_antiwindup_checker
module pid_controller_antiwindup_tb;
    import pidaw_pkg::*;

    localparam int CLK_HI        = 6;
    localparam int CLK_LO        = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SQUEEZE_BEATS = 40;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_BEATS   = 50;
    localparam int TAIL_CYCLES   = 10;

    localparam logic [DATA_W-1:0] ONE = 32'h0001_0000;

    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic                      s_operation    = OP_STEP;
    logic signed [DATA_W-1:0]  s_error_sample = '0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic signed [DATA_W-1:0]  m_drive;
    logic                      cfg_valid      = 1'b0;
    logic                      cfg_ready;
    logic [CFG_ADDR_W-1:0]     cfg_addr       = REG_MODE;
    logic [DATA_W-1:0]         cfg_wdata      = '0;

    int bad_beats;
    int pending;
    int drives_seen;
    int cycle_count   = 0;
    int settings_used = 0;
    bit calm          = 1'b0;
    bit squeeze       = 1'b0;

    pid_controller_antiwindup dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_error_sample (s_error_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive        (m_drive),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata)
    );

    pid_controller_antiwindup_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_error_sample (s_error_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive        (m_drive),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .bad_beats      (bad_beats),
        .pending        (pending),
        .drives_seen    (drives_seen)
    );

    // clock
    always begin
        aclk = 1'b0;
        #CLK_LO;
        aclk = 1'b1;
        #CLK_HI;
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("pid_controller_antiwindup: mismatch");
            $finish;
        end
    end

    // mostly short idles, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DATA_W-1:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return '0;
            3, 4:    return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    // clamp or deadband magnitude; bit 31 may carry junk
    function automatic logic [DATA_W-1:0] rand_span();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom_range(0, 32'h0008_0000);
            4:       return $urandom_range(0, 32'h0000_4000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_error();
        case ($urandom_range(0, 9))
            0:          return DATA_MAX;
            1:          return DATA_MIN;
            2:          return '0;
            3, 4, 5, 6: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            7:          return $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
            default:    return $urandom;
        endcase
    endfunction

    // receiver: random stalls, a free-running stretch when calm, one long hold-off on request
    initial begin : receiver
        int stall;
        wait (aresetn);
        forever begin
            if (squeeze) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                squeeze = 1'b0;
            end else if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                stall = idle_len();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    end

    // one register write beat; valid stays up for a following write
    task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_regs(
        input logic [DATA_W-1:0] mode_val,
        input logic [DATA_W-1:0] kp_val,
        input logic [DATA_W-1:0] ki_val,
        input logic [DATA_W-1:0] kd_val,
        input logic [DATA_W-1:0] lim_val,
        input logic [DATA_W-1:0] band_val
    );
        write_reg(REG_MODE, mode_val);
        write_reg(REG_KP, kp_val);
        write_reg(REG_KI_TS, ki_val);
        write_reg(REG_KD_TS, kd_val);
        write_reg(REG_LIMIT, lim_val);
        write_reg(REG_DEADBAND, band_val);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // one input beat with an optional idle in front
    task automatic send_beat(input logic op, input logic [DATA_W-1:0] err);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_error_sample <= err;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait until every predicted drive has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic rand_step();
        if ($urandom_range(0, 9) == 0) begin
            send_beat(OP_CLEAR, $urandom);
        end else begin
            send_beat(OP_STEP, rand_error());
        end
    endtask

    task automatic rand_program();
        logic [DATA_W-1:0] mode_val;
        mode_val = $urandom;
        mode_val[MODE_W-1:0] = MODE_W'($urandom_range(0, 3));
        program_regs(mode_val, rand_gain(), rand_gain(), rand_gain(), rand_span(), rand_span());
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values: zero gains and zero clamp
        send_beat(OP_STEP, DATA_MAX);
        send_beat(OP_STEP, DATA_MIN);
        send_beat(OP_CLEAR, DATA_MAX);
        drain();

        // full pid, deadband edges and a saturating error difference
        program_regs(MODE_PID, ONE, ONE >> 1, ONE >> 2, 32'h7FFF_FFFF, 32'h0000_0100);
        send_beat(OP_STEP, 32'h0000_0100);
        send_beat(OP_STEP, -32'sh0000_0100);
        send_beat(OP_STEP, 32'h0000_0101);
        send_beat(OP_STEP, -32'sh0000_0101);
        send_beat(OP_STEP, DATA_MAX);
        send_beat(OP_STEP, DATA_MIN);
        send_beat(OP_CLEAR, '0);
        drain();

        // clamping: integral held while pushing out, committed while pulling back
        program_regs(MODE_PID, ONE, ONE, '0, 32'h0003_0000, '0);
        repeat (3) send_beat(OP_STEP, ONE);
        send_beat(OP_STEP, -ONE);
        send_beat(OP_STEP, -(ONE << 2));
        drain();

        // pd only: deadband early exit clears the last error
        program_regs(MODE_PD, ONE << 1, ONE, ONE, 32'h7FFF_FFFF, 32'h0000_8000);
        send_beat(OP_STEP, 32'h0002_0000);
        send_beat(OP_STEP, 32'h0000_4000);
        send_beat(OP_STEP, 32'h0003_0000);
        send_beat(OP_STEP, -32'sh0000_8001);
        drain();

        // pi only with saturating products
        program_regs(MODE_PI, DATA_MIN, DATA_MAX, DATA_MAX, 32'h7FFF_FFFF, '0);
        send_beat(OP_STEP, DATA_MIN);
        send_beat(OP_STEP, DATA_MAX);
        drain();

        // unused mode code with junk upper bits, widest clamp written with bit 31 set
        program_regs(32'hFFFF_FFF3, DATA_MAX, DATA_MIN, DATA_MIN, 32'hFFFF_FFFF, '0);
        send_beat(OP_STEP, DATA_MIN);
        send_beat(OP_STEP, DATA_MAX);
        drain();

        // widest deadband swallows every error but the most negative one
        program_regs(MODE_PID, ONE, ONE, ONE, 32'h0001_0000, 32'h7FFF_FFFF);
        send_beat(OP_STEP, DATA_MIN);
        send_beat(OP_STEP, DATA_MAX);
        drain();

        // output held off for a long stretch while input keeps coming
        rand_program();
        calm    = 1'b1;
        squeeze = 1'b1;
        repeat (SQUEEZE_BEATS) rand_step();
        calm = 1'b0;
        drain();

        // random settings and random beats
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            rand_program();
            calm = ($urandom_range(0, 3) == 0);
            repeat (PHASE_BEATS) rand_step();
            calm = 1'b0;
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("checked %0d drive beats over %0d register settings", drives_seen,
                 settings_used);
        $display("covered all mode codes, clears, deadband edges, clamping and saturation");
        if (bad_beats == 0 && pending == 0) begin
            $display("pid_controller_antiwindup: match");
        end else begin
            $display("pid_controller_antiwindup: mismatch");
        end
        $finish;
    end

endmodule
